### rtl/core/lbu_pkg.sv
// Package for the letterbox box unmapper: widths, register indexes,
// payload structs and the size-clamping helper. No dependencies.
package lbu_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 20;
    localparam int CFRAC     = 4;
    localparam int NORM_W    = 17;
    localparam int NFRAC     = 16;
    localparam int PROD_W    = 25;
    localparam int AQ_W      = 14;
    localparam int AREM_W    = 12;
    localparam int PAD_W     = 12;
    localparam int D_W       = PROD_W + CFRAC;
    localparam int P_W       = COORD_W + DIM_W;
    localparam int CFG_IDX_W = 3;
    localparam int NSTG      = 37;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 3'd4;

    localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0] RST_MODEL_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0] RST_MODEL_HEIGHT  = 13'd640;

    localparam logic [NORM_W-1:0] NORM_ONE = 17'd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_edge;
        logic signed [COORD_W-1:0] top_edge;
        logic signed [COORD_W-1:0] right_edge;
        logic signed [COORD_W-1:0] bottom_edge;
    } t_box_in;

    typedef struct packed {
        logic [NORM_W-1:0] left_norm;
        logic [NORM_W-1:0] top_norm;
        logic [NORM_W-1:0] right_norm;
        logic [NORM_W-1:0] bottom_norm;
        logic              box_valid;
    } t_box_out;

    // Clamp a size register into the range 1 to MAX_DIM.
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] v;
        v = r;
        if (r == '0) begin
            v = DIM_W'(1);
        end else if (r > DIM_W'(MAX_DIM)) begin
            v = DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

endpackage

### rtl/core/letterbox_box_unmapper_core.sv
// Top level of the letterbox box unmapper: a 37-stage pipeline that maps a
// model-pixel box to source-normalised coordinates. Depends on lbu_pkg.
//
// Usage. Boxes arrive on the input channel (i_valid, o_stall, i_box) and
// results leave on the output channel (o_valid, i_stall, o_box). A transfer
// happens at a rising edge where valid is high and stall is low.
// One box may be transferred in each cycle that o_stall is low, so
// throughput is one box per cycle unless the receiver stalls. The depth
// is set by two bit-serial dividers laid out as pipeline stages: 14 stages
// for the letterbox active size and 17 stages for the normalised quotient.
// Geometry (cross products, active size, padding) is recomputed from the
// registers for every box, so it always follows the current configuration.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data, and
// should only change while the pipeline is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the
// register defaults: 640 x 480 source, 640 x 640 model, letterbox mode.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises, so nothing is lost or repeated.
module letterbox_box_unmapper_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  lbu_pkg::t_box_in                i_box,
    output logic                            o_valid,
    input  logic                            i_stall,
    output lbu_pkg::t_box_out               o_box,
    input  logic                            i_cfg_we,
    input  logic [lbu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbu_pkg::DIM_W-1:0]       i_cfg_data
);

    localparam int DW  = lbu_pkg::DIM_W;
    localparam int PW  = lbu_pkg::PROD_W;
    localparam int AQ  = lbu_pkg::AQ_W;
    localparam int AR  = lbu_pkg::AREM_W;
    localparam int DD  = lbu_pkg::D_W;
    localparam int MP  = lbu_pkg::P_W;
    localparam int NW  = lbu_pkg::NORM_W;
    localparam int CW  = lbu_pkg::COORD_W;

    // Geometry that travels with a box through the active-size divider.
    typedef struct packed {
        lbu_pkg::t_box_in box;
        logic             fit;
        logic             ycase;
        logic [DW-1:0]    num;
        logic [PW-1:0]    den;
        logic [DW-1:0]    mdim;
        logic [DW-1:0]    dv;
        logic [DW-1:0]    mw;
        logic [DW-1:0]    mh;
    } t_geo;

    typedef struct packed {
        logic [lbu_pkg::PAD_W-1:0] pad;
        logic [DW-1:0]             num;
        logic [PW-1:0]             den;
    } t_axis;

    // ---------------------------------------------------------------
    // Configuration registers.
    // ---------------------------------------------------------------
    logic [DW-1:0] r_src_w, r_src_h, r_mdl_w, r_mdl_h;
    logic          r_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= lbu_pkg::RST_SOURCE_WIDTH;
            r_src_h <= lbu_pkg::RST_SOURCE_HEIGHT;
            r_mdl_w <= lbu_pkg::RST_MODEL_WIDTH;
            r_mdl_h <= lbu_pkg::RST_MODEL_HEIGHT;
            r_fit   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lbu_pkg::REG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                lbu_pkg::REG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                lbu_pkg::REG_MODEL_WIDTH:   r_mdl_w <= i_cfg_data;
                lbu_pkg::REG_MODEL_HEIGHT:  r_mdl_h <= i_cfg_data;
                lbu_pkg::REG_FIT_MODE:      r_fit   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: every stage advances together.
    // ---------------------------------------------------------------
    logic                     en;
    logic [lbu_pkg::NSTG-1:0] r_vld;

    assign en      = !r_vld[lbu_pkg::NSTG-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[lbu_pkg::NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[lbu_pkg::NSTG-2:0], i_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: clamp the sizes and form both cross products.
    // ---------------------------------------------------------------
    logic [DW-1:0]     sw, sh, mw, mh;
    logic [2*DW-1:0]   prod_a, prod_b;
    lbu_pkg::t_box_in  r_s1_box;
    logic              r_s1_fit;
    logic [DW-1:0]     r_s1_sw, r_s1_sh, r_s1_mw, r_s1_mh;
    logic [PW-1:0]     r_s1_pa, r_s1_pb;

    assign sw     = lbu_pkg::dim_of(r_src_w);
    assign sh     = lbu_pkg::dim_of(r_src_h);
    assign mw     = lbu_pkg::dim_of(r_mdl_w);
    assign mh     = lbu_pkg::dim_of(r_mdl_h);
    assign prod_a = sw * mh;
    assign prod_b = sh * mw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_box <= i_box;
            r_s1_fit <= r_fit;
            r_s1_sw  <= sw;
            r_s1_sh  <= sh;
            r_s1_mw  <= mw;
            r_s1_mh  <= mh;
            r_s1_pa  <= prod_a[PW-1:0];
            r_s1_pb  <= prod_b[PW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: pick the limiting axis and load the active-size divider,
    // which yields floor(2 * A / dv) one bit per stage.
    // ---------------------------------------------------------------
    t_geo          r_geo  [0:AQ];
    logic [AR-1:0] r_arem [0:AQ];
    logic [AQ-1:0] r_alow [0:AQ];
    logic [AQ-1:0] r_aq   [0:AQ];
    t_geo          n_geo;
    logic [PW-1:0] a_num;

    always_comb begin
        n_geo.box   = r_s1_box;
        n_geo.fit   = r_s1_fit;
        n_geo.ycase = (r_s1_pa >= r_s1_pb);
        n_geo.mw    = r_s1_mw;
        n_geo.mh    = r_s1_mh;
        if (n_geo.ycase) begin
            a_num      = r_s1_pb;
            n_geo.dv   = r_s1_sw;
            n_geo.den  = r_s1_pb;
            n_geo.num  = r_s1_sw;
            n_geo.mdim = r_s1_mh;
        end else begin
            a_num      = r_s1_pa;
            n_geo.dv   = r_s1_sh;
            n_geo.den  = r_s1_pa;
            n_geo.num  = r_s1_sh;
            n_geo.mdim = r_s1_mw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo[0]  <= n_geo;
            r_arem[0] <= a_num[PW-1:DW];
            r_alow[0] <= {a_num[DW-1:0], 1'b0};
            r_aq[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= AQ; k++) begin : g_adiv
        logic [AR:0] rr;
        logic        ge;
        assign rr = {r_arem[k-1], r_alow[k-1][AQ-1]};
        assign ge = (rr >= r_geo[k-1].dv);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_geo[k]  <= r_geo[k-1];
                r_alow[k] <= {r_alow[k-1][AQ-2:0], 1'b0};
                r_aq[k]   <= {r_aq[k-1][AQ-2:0], ge};
                r_arem[k] <= ge ? AR'(rr - r_geo[k-1].dv) : rr[AR-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage P: round the active size half up, clamp it, split the pad and
    // set up the per-axis scale.
    // ---------------------------------------------------------------
    logic [AQ:0]   ah_sum;
    logic [AQ-1:0] ah_r;
    logic [DW-1:0] ah;
    logic [DW-1:0] pad_diff;
    t_axis         n_ax_x, n_ax_y, r_ax_x, r_ax_y;
    lbu_pkg::t_box_in r_p_box;

    always_comb begin
        ah_sum   = {1'b0, r_aq[AQ]} + (AQ+1)'(1);
        ah_r     = ah_sum[AQ:1];
        if (ah_r == '0) begin
            ah = DW'(1);
        end else if (ah_r > {1'b0, r_geo[AQ].mdim}) begin
            ah = r_geo[AQ].mdim;
        end else begin
            ah = ah_r[DW-1:0];
        end
        pad_diff = r_geo[AQ].mdim - ah;
        n_ax_x.pad = '0;
        n_ax_x.num = DW'(1);
        n_ax_x.den = PW'(r_geo[AQ].mw);
        n_ax_y.pad = '0;
        n_ax_y.num = DW'(1);
        n_ax_y.den = PW'(r_geo[AQ].mh);
        if (r_geo[AQ].fit) begin
            if (r_geo[AQ].ycase) begin
                n_ax_y.pad = pad_diff[DW-1:1];
                n_ax_y.num = r_geo[AQ].num;
                n_ax_y.den = r_geo[AQ].den;
            end else begin
                n_ax_x.pad = pad_diff[DW-1:1];
                n_ax_x.num = r_geo[AQ].num;
                n_ax_x.den = r_geo[AQ].den;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax_x  <= n_ax_x;
            r_ax_y  <= n_ax_y;
            r_p_box <= r_geo[AQ].box;
        end
    end

    // ---------------------------------------------------------------
    // Stage M: remove the leading pad and multiply by the scale numerator.
    // Coordinates 0 and 2 are horizontal, 1 and 3 vertical.
    // ---------------------------------------------------------------
    logic signed [CW-1:0] coord [0:3];
    logic [MP-1:0]        r_m_p   [0:3];
    logic                 r_m_pos [0:3];
    logic [DD-1:0]        r_m_d   [0:1];
    logic                 r_m_rgtl, r_m_bgtt;

    assign coord[0] = r_p_box.left_edge;
    assign coord[1] = r_p_box.top_edge;
    assign coord[2] = r_p_box.right_edge;
    assign coord[3] = r_p_box.bottom_edge;

    for (genvar c = 0; c < 4; c++) begin : g_mul
        t_axis             ax;
        logic signed [CW:0] nv;
        assign ax = (c % 2 == 0) ? r_ax_x : r_ax_y;
        assign nv = {coord[c][CW-1], coord[c]}
                  - $signed({1'b0, ax.pad, {lbu_pkg::CFRAC{1'b0}}});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m_pos[c] <= (nv > 0);
                r_m_p[c]   <= nv[CW-1:0] * ax.num;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_d[0] <= {r_ax_x.den, {lbu_pkg::CFRAC{1'b0}}};
            r_m_d[1] <= {r_ax_y.den, {lbu_pkg::CFRAC{1'b0}}};
            r_m_rgtl <= (r_p_box.right_edge > r_p_box.left_edge);
            r_m_bgtt <= (r_p_box.bottom_edge > r_p_box.top_edge);
        end
    end

    // ---------------------------------------------------------------
    // Stage C and the normalising divider: saturate at 1.0, otherwise
    // form floor(p * 2^17 / d) one bit per stage.
    // ---------------------------------------------------------------
    logic [DD-1:0] r_nrem [0:NW][0:3];
    logic [NW-1:0] r_nq   [0:NW][0:3];
    logic          r_nsat [0:NW][0:3];
    logic          r_npos [0:NW][0:3];
    logic [DD-1:0] r_nd   [0:NW][0:1];
    logic          r_nrgtl [0:NW];
    logic          r_nbgtt [0:NW];

    for (genvar c = 0; c < 4; c++) begin : g_ninit
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nsat[0][c] <= (r_m_p[c] >= MP'(r_m_d[c % 2]));
                r_npos[0][c] <= r_m_pos[c];
                r_nrem[0][c] <= r_m_p[c][DD-1:0];
                r_nq[0][c]   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nd[0][0]  <= r_m_d[0];
            r_nd[0][1]  <= r_m_d[1];
            r_nrgtl[0]  <= r_m_rgtl;
            r_nbgtt[0]  <= r_m_bgtt;
        end
    end

    for (genvar k = 1; k <= NW; k++) begin : g_ndiv
        for (genvar c = 0; c < 4; c++) begin : g_lane
            logic [DD:0] rr;
            logic        ge;
            assign rr = {r_nrem[k-1][c], 1'b0};
            assign ge = (rr >= {1'b0, r_nd[k-1][c % 2]});
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_nrem[k][c] <= ge ? DD'(rr - {1'b0, r_nd[k-1][c % 2]})
                                       : rr[DD-1:0];
                    r_nq[k][c]   <= {r_nq[k-1][c][NW-2:0], ge};
                    r_nsat[k][c] <= r_nsat[k-1][c];
                    r_npos[k][c] <= r_npos[k-1][c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nd[k][0] <= r_nd[k-1][0];
                r_nd[k][1] <= r_nd[k-1][1];
                r_nrgtl[k] <= r_nrgtl[k-1];
                r_nbgtt[k] <= r_nbgtt[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: round half up, saturate and judge validity.
    // ---------------------------------------------------------------
    logic [NW-1:0] nval  [0:3];
    logic          below [0:3];
    logic          n_ok;
    lbu_pkg::t_box_out n_out, r_out;

    for (genvar c = 0; c < 4; c++) begin : g_fin
        logic [NW:0] qs;
        assign qs = {1'b0, r_nq[NW][c]} + (NW+1)'(1);
        assign below[c] = !r_npos[NW][c] || !r_nsat[NW][c];
        assign nval[c]  = !r_npos[NW][c] ? '0
                        : r_nsat[NW][c] ? lbu_pkg::NORM_ONE
                        : qs[NW:1];
    end

    always_comb begin
        n_ok = r_nrgtl[NW] && r_npos[NW][2] && below[0]
            && r_nbgtt[NW] && r_npos[NW][3] && below[1];
        n_out.box_valid   = n_ok;
        n_out.left_norm   = n_ok ? nval[0] : '0;
        n_out.top_norm    = n_ok ? nval[1] : '0;
        n_out.right_norm  = n_ok ? nval[2] : '0;
        n_out.bottom_norm = n_ok ? nval[3] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_box = r_out;

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_box.box_valid) |-> (o_box.left_norm == '0
            && o_box.top_norm == '0 && o_box.right_norm == '0
            && o_box.bottom_norm == '0))
        else $error("invalid box with non-zero coordinates");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box.left_norm <= lbu_pkg::NORM_ONE
            && o_box.top_norm <= lbu_pkg::NORM_ONE
            && o_box.right_norm <= lbu_pkg::NORM_ONE
            && o_box.bottom_norm <= lbu_pkg::NORM_ONE))
        else $error("normalised coordinate above 1.0");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_box.box_valid) |-> (o_box.left_norm <= o_box.right_norm
            && o_box.top_norm <= o_box.bottom_norm))
        else $error("valid box with crossed edges");

endmodule
